@@ design/sea_pkg.sv @@
// Shared constants, codes and types of the stack expression ALU.
`timescale 1ns / 1ps

package sea_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int DATA_W      = 16;
    localparam int CMD_W       = 4;
    localparam int STS_W       = 2;
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(DATA_W + 1);
    localparam int ADDR_W      = 3;

    // Command codes; the two top codes are unused and act as null.
    localparam logic [CMD_W-1:0] CMD_NULL = 4'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH = 4'd1;
    localparam logic [CMD_W-1:0] CMD_ADD  = 4'd2;
    localparam logic [CMD_W-1:0] CMD_SUB  = 4'd3;
    localparam logic [CMD_W-1:0] CMD_MUL  = 4'd4;
    localparam logic [CMD_W-1:0] CMD_DIV  = 4'd5;
    localparam logic [CMD_W-1:0] CMD_MOD  = 4'd6;
    localparam logic [CMD_W-1:0] CMD_OR   = 4'd7;
    localparam logic [CMD_W-1:0] CMD_AND  = 4'd8;
    localparam logic [CMD_W-1:0] CMD_EQ   = 4'd9;
    localparam logic [CMD_W-1:0] CMD_NE   = 4'd10;
    localparam logic [CMD_W-1:0] CMD_GT   = 4'd11;
    localparam logic [CMD_W-1:0] CMD_LT   = 4'd12;
    localparam logic [CMD_W-1:0] CMD_RAND = 4'd13;

    localparam logic [STS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STS_W-1:0] STS_UNDER = 2'd1;
    localparam logic [STS_W-1:0] STS_OVER  = 2'd2;
    localparam logic [STS_W-1:0] STS_DIVZ  = 2'd3;

    // Register index decoded from paddr[ADDR_W-1:2].
    localparam logic [ADDR_W-3:0] REG_INIT_SEED = 1'b0;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        logic [DATA_W-1:0] data;
    } stk_wr_t;

    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic              done;
        logic [DATA_W-1:0] quotient;
        logic [DATA_W-1:0] remainder;
    } div_rsp_t;

endpackage

@@ design/sea_if.sv @@
// Valid/ready channel interfaces for commands and results.
`timescale 1ns / 1ps

interface sea_req_if import sea_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [DATA_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface sea_rsp_if import sea_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] top_value;
    logic [SP_W-1:0]   stack_depth;
    logic [STS_W-1:0]  status;

    modport source (output valid, output top_value, output stack_depth, output status,
                    input ready);
    modport sink   (input valid, input top_value, input stack_depth, input status,
                    output ready);
endinterface

@@ design/sea_stack.sv @@
// Operand stack memory: one write port, two registered read ports.
`timescale 1ns / 1ps

module sea_stack import sea_pkg::*; (
    input  logic              clk,
    input  stk_wr_t           wr,
    input  logic [IDX_W-1:0]  rd_addr_a,
    input  logic [IDX_W-1:0]  rd_addr_b,
    output logic [DATA_W-1:0] rd_data_a,
    output logic [DATA_W-1:0] rd_data_b
);

    logic [DATA_W-1:0] mem [STACK_DEPTH];
    logic [DATA_W-1:0] rd_a_reg;
    logic [DATA_W-1:0] rd_b_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_a_reg <= mem[rd_addr_a];
        rd_b_reg <= mem[rd_addr_b];
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

@@ design/sea_div.sv @@
// Shared restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module sea_div import sea_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] dvs_reg;

    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic [DATA_W-1:0] rem_next;

    // Shift in the next dividend bit and try the subtract.
    assign shifted  = {rem_reg, quo_reg[DATA_W-1]};
    assign diff     = shifted - {1'b0, dvs_reg};
    assign rem_next = diff[DATA_W] ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DATA_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DATA_W-2:0], ~diff[DATA_W]};
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

@@ design/stack_expression_alu_unit.sv @@
// Top level of the stack expression ALU: sequencer, config port and result register.
`timescale 1ns / 1ps

//  channel   dir  transfer when          payload
//  req       in   req.valid & req.ready  cmd[3:0], value[15:0]
//  rsp       out  rsp.valid & rsp.ready  top_value[15:0], stack_depth[4:0], status[1:0]
//  apb       in   psel&penable&pwrite    paddr[2:0], pwdata[31:0] (seed at 0x0)
//
//  Div, mod and random that pass their checks wait in DIV for the shared divider;
//  every other command, and any that fails a check, goes from EXEC straight to DONE.
//  req.ready is high only while the sequencer is idle; one command is in flight.
//  A finished result waits in the output register; a new command is taken
//  meanwhile, and its own result holds in the final state until rsp drains.
//  Reset clears the stack pointer, the seed and the seed register.

module stack_expression_alu_unit import sea_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    sea_req_if.sink           req,
    sea_rsp_if.source         rsp
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_DIV  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [CMD_W-1:0]  cmd_reg;
    logic [DATA_W-1:0] value_reg;
    logic [SP_W-1:0]   sp_reg;
    logic [SP_W-1:0]   sp_new_reg, sp_new_next;
    logic [DATA_W-1:0] seed_reg, seed_next;
    logic [DATA_W-1:0] init_seed_reg;
    logic [DATA_W-1:0] res_reg, res_next;
    logic [STS_W-1:0]  status_reg, status_next;
    logic              wr_pend_reg, wr_pend_next;
    logic [IDX_W-1:0]  wr_addr_reg, wr_addr_next;
    logic              use_rem_reg, use_rem_next;

    logic              rsp_valid_reg;
    logic [DATA_W-1:0] rsp_top_reg;
    logic [SP_W-1:0]   rsp_depth_reg;
    logic [STS_W-1:0]  rsp_status_reg;

    logic              accept;
    logic              cfg_we;
    logic              finish;
    logic [SP_W-1:0]   sp_m1;
    logic [SP_W-1:0]   sp_m2;
    logic [DATA_W-1:0] opnd_a;
    logic [DATA_W-1:0] opnd_b;
    logic [DATA_W-1:0] alu_result;
    logic [2*DATA_W-1:0] product;
    logic [DATA_W-1:0] seed_step;
    logic [DATA_W-1:0] top_next;
    logic              stack_full;
    logic              is_binary;
    logic              is_divmod;

    stk_wr_t           stk_wr;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    // ------------------------------------------------------------------
    // Configuration port: the seed register also loads the live seed.
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[ADDR_W-1:2] == REG_INIT_SEED);
    assign prdata = (paddr[ADDR_W-1:2] == REG_INIT_SEED) ? 32'(init_seed_reg) : 32'd0;

    // ------------------------------------------------------------------
    // Stack memory. The read addresses follow the stack pointer at all
    // times, so the two top words are ready in the cycle after accept.
    // ------------------------------------------------------------------
    assign sp_m1 = sp_reg - SP_W'(1);
    assign sp_m2 = sp_reg - SP_W'(2);

    sea_stack u_stack (
        .clk       (clk),
        .wr        (stk_wr),
        .rd_addr_a (sp_m2[IDX_W-1:0]),
        .rd_addr_b (sp_m1[IDX_W-1:0]),
        .rd_data_a (opnd_a),
        .rd_data_b (opnd_b)
    );

    sea_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // ------------------------------------------------------------------
    // Operations computed in EXEC; div and mod go through the shared divider.
    // ------------------------------------------------------------------
    assign product   = opnd_a * opnd_b;
    assign seed_step = seed_reg + {seed_reg[DATA_W-3:0], 2'b00} + DATA_W'(1);

    always_comb
    begin
        unique case (cmd_reg)
            CMD_ADD: alu_result = opnd_a + opnd_b;
            CMD_SUB: alu_result = (opnd_a > opnd_b) ? (opnd_a - opnd_b) : '0;
            CMD_MUL: alu_result = product[DATA_W-1:0];
            CMD_OR:  alu_result = opnd_a | opnd_b;
            CMD_AND: alu_result = opnd_a & opnd_b;
            CMD_EQ:  alu_result = DATA_W'(opnd_a == opnd_b);
            CMD_NE:  alu_result = DATA_W'(opnd_a != opnd_b);
            CMD_GT:  alu_result = DATA_W'(opnd_a > opnd_b);
            CMD_LT:  alu_result = DATA_W'(opnd_a < opnd_b);
            default: alu_result = '0;
        endcase
    end

    assign stack_full = (sp_reg == SP_W'(STACK_DEPTH));
    assign is_binary  = (cmd_reg >= CMD_ADD) && (cmd_reg <= CMD_LT);
    assign is_divmod  = (cmd_reg == CMD_DIV) || (cmd_reg == CMD_MOD);

    assign accept = req.valid && req.ready;
    assign finish = (state_reg == S_DONE) && (!rsp_valid_reg || rsp.ready);

    // ------------------------------------------------------------------
    // Sequencer: EXEC checks and computes, DIV waits on the divider,
    // DONE commits the stack write and loads the output register.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        sp_new_next      = sp_new_reg;
        seed_next        = seed_reg;
        res_next         = res_reg;
        status_next      = status_reg;
        wr_pend_next     = wr_pend_reg;
        wr_addr_next     = wr_addr_reg;
        use_rem_next     = use_rem_reg;
        div_req.start    = 1'b0;
        div_req.dividend = opnd_a;
        div_req.divisor  = opnd_b;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                status_next  = STS_OK;
                wr_pend_next = 1'b0;
                sp_new_next  = sp_reg;
                state_next   = S_DONE;
                priority if (cmd_reg == CMD_PUSH)
                begin
                    if (stack_full)
                    begin
                        status_next = STS_OVER;
                    end
                    else
                    begin
                        wr_pend_next = 1'b1;
                        wr_addr_next = sp_reg[IDX_W-1:0];
                        res_next     = value_reg;
                        sp_new_next  = sp_reg + SP_W'(1);
                    end
                end
                else if (is_binary)
                begin
                    if (sp_reg < SP_W'(2))
                    begin
                        status_next = STS_UNDER;
                    end
                    else if (is_divmod && (opnd_b == '0))
                    begin
                        status_next = STS_DIVZ;
                    end
                    else
                    begin
                        wr_pend_next = 1'b1;
                        wr_addr_next = sp_m2[IDX_W-1:0];
                        sp_new_next  = sp_m1;
                        res_next     = alu_result;
                        if (is_divmod)
                        begin
                            div_req.start = 1'b1;
                            use_rem_next  = (cmd_reg == CMD_MOD);
                            state_next    = S_DIV;
                        end
                    end
                end
                else if (cmd_reg == CMD_RAND)
                begin
                    if (stack_full)
                    begin
                        status_next = STS_OVER;
                    end
                    else if (value_reg == '0)
                    begin
                        status_next = STS_DIVZ;
                    end
                    else
                    begin
                        // Step the seed, then reduce it by the range.
                        seed_next        = seed_step;
                        div_req.start    = 1'b1;
                        div_req.dividend = seed_step;
                        div_req.divisor  = value_reg;
                        use_rem_next     = 1'b1;
                        wr_pend_next     = 1'b1;
                        wr_addr_next     = sp_reg[IDX_W-1:0];
                        sp_new_next      = sp_reg + SP_W'(1);
                        state_next       = S_DIV;
                    end
                end
                else
                begin
                    status_next = STS_OK;
                end
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    res_next   = use_rem_reg ? div_rsp.remainder : div_rsp.quotient;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (finish)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            seed_next = pwdata[DATA_W-1:0];
        end
    end

    // Top after the step: the new word if one is written, else the old top.
    always_comb
    begin
        priority if (wr_pend_reg)
        begin
            top_next = res_reg;
        end
        else if (sp_reg != '0)
        begin
            top_next = opnd_b;
        end
        else
        begin
            top_next = '0;
        end
    end

    assign stk_wr.en   = finish && wr_pend_reg;
    assign stk_wr.addr = wr_addr_reg;
    assign stk_wr.data = res_reg;

    assign req.ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            sp_reg        <= '0;
            seed_reg      <= '0;
            init_seed_reg <= '0;
            rsp_valid_reg <= 1'b0;
            wr_pend_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            seed_reg    <= seed_next;
            wr_pend_reg <= wr_pend_next;
            if (cfg_we)
            begin
                init_seed_reg <= pwdata[DATA_W-1:0];
            end
            if (finish)
            begin
                sp_reg        <= sp_new_reg;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Command, work and result payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg   <= req.cmd;
            value_reg <= req.value;
        end
        sp_new_reg  <= sp_new_next;
        res_reg     <= res_next;
        status_reg  <= status_next;
        wr_addr_reg <= wr_addr_next;
        use_rem_reg <= use_rem_next;
        if (finish)
        begin
            rsp_top_reg    <= top_next;
            rsp_depth_reg  <= sp_new_reg;
            rsp_status_reg <= status_reg;
        end
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.top_value   = rsp_top_reg;
    assign rsp.stack_depth = rsp_depth_reg;
    assign rsp.status      = rsp_status_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond stack depth");

    a_sp_only_at_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_DONE) |=> $stable(sp_reg))
        else $error("stack pointer moved outside commit");

    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_EXEC))
        else $error("accepted command did not enter execute");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == S_DIV))
        else $error("divider finished outside divide wait");

    a_under_depth: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status == STS_UNDER)) |-> (rsp.stack_depth < SP_W'(2)))
        else $error("underflow reported with two or more words held");

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the stack expression ALU unit.
`timescale 1ns / 1ps

module testbench;
    import sea_pkg::*;

    // The two top command codes are unused; the block treats them as null.
    localparam logic [CMD_W-1:0] CMD_SPARE_E = 4'd14;
    localparam logic [CMD_W-1:0] CMD_SPARE_F = 4'd15;

    // Settling wait after a drain; the longest commands (div, mod, random) use the divider.
    localparam int LATENCY_CYCLES = 24;
    // Run limit: about 1000 commands in the worst case fit in it many times over.
    localparam int RUN_LIMIT_NS   = 5_000_000;
    localparam int IDLE_PERCENT   = 14;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] value;
    } alu_item_t;

    // What the block reports after one command: top word, depth and status.
    typedef struct packed {
        logic [DATA_W-1:0] top;
        logic [SP_W-1:0]   depth;
        logic [STS_W-1:0]  status;
    } stack_view_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    sea_req_if req_ch ();
    sea_rsp_if rsp_ch ();

    stack_expression_alu_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .req     (req_ch),
        .rsp     (rsp_ch)
    );

    // Commands waiting to be driven, and the views expected back, oldest first.
    alu_item_t   cmd_backlog[$];
    stack_view_t predicted_views[$];

    // Shadow copy of the block's state, advanced once per accepted command.
    logic [DATA_W-1:0] shadow_stack [STACK_DEPTH];
    int                shadow_held = 0;
    logic [DATA_W-1:0] shadow_seed = '0;

    // Rough depth estimate used only to shape the stimulus; resynced when drained.
    int        gen_depth = 0;
    int        mismatches = 0;
    bit        steady_flow = 1'b0;
    alu_item_t next_item;

    // Hold clk low 5 ns, high 5 ns.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
        mismatches++;
    endtask

    // Advance the shadow state by one command and queue the view it leaves behind.
    function automatic void predict_step(input logic [CMD_W-1:0] c, input logic [DATA_W-1:0] v);
        logic [DATA_W-1:0]   a;
        logic [DATA_W-1:0]   b;
        logic [DATA_W-1:0]   r;
        logic [2*DATA_W-1:0] prod;
        logic [STS_W-1:0]    st;
        stack_view_t         view;
        st = STS_OK;
        if (c == CMD_PUSH)
        begin
            if (shadow_held >= STACK_DEPTH)
                st = STS_OVER;
            else
            begin
                shadow_stack[shadow_held] = v;
                shadow_held++;
            end
        end
        else if (c >= CMD_ADD && c <= CMD_LT)
        begin
            if (shadow_held < 2)
                st = STS_UNDER;
            else
            begin
                b = shadow_stack[shadow_held - 1];
                a = shadow_stack[shadow_held - 2];
                if ((c == CMD_DIV || c == CMD_MOD) && b == '0)
                    st = STS_DIVZ;
                else
                begin
                    prod = a * b;
                    case (c)
                        CMD_ADD: r = a + b;
                        CMD_SUB: r = (a > b) ? a - b : '0;
                        CMD_MUL: r = prod[DATA_W-1:0];
                        CMD_DIV: r = a / b;
                        CMD_MOD: r = a % b;
                        CMD_OR:  r = a | b;
                        CMD_AND: r = a & b;
                        CMD_EQ:  r = (a == b) ? 16'd1 : 16'd0;
                        CMD_NE:  r = (a != b) ? 16'd1 : 16'd0;
                        CMD_GT:  r = (a > b) ? 16'd1 : 16'd0;
                        default: r = (a < b) ? 16'd1 : 16'd0;
                    endcase
                    shadow_stack[shadow_held - 2] = r;
                    shadow_held--;
                end
            end
        end
        else if (c == CMD_RAND)
        begin
            if (shadow_held >= STACK_DEPTH)
                st = STS_OVER;
            else if (v == '0)
                st = STS_DIVZ;
            else
            begin
                shadow_seed = shadow_seed * 16'd5 + 16'd1;
                shadow_stack[shadow_held] = shadow_seed % v;
                shadow_held++;
            end
        end
        view.top    = (shadow_held > 0) ? shadow_stack[shadow_held - 1] : '0;
        view.depth  = SP_W'(shadow_held);
        view.status = st;
        predicted_views.push_back(view);
    endfunction

    // Driver: present the next command once the previous transfer is done,
    // and leave valid low now and then unless the flow is held steady.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_ch.cmd   <= CMD_NULL;
            req_ch.value <= '0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
                predict_step(req_ch.cmd, req_ch.value);
            if (!req_ch.valid || req_ch.ready)
            begin
                if (cmd_backlog.size() != 0 &&
                    (steady_flow || $urandom_range(0, 99) >= IDLE_PERCENT))
                begin
                    next_item    = cmd_backlog.pop_front();
                    req_ch.valid <= 1'b1;
                    req_ch.cmd   <= next_item.cmd;
                    req_ch.value <= next_item.value;
                end
                else
                    req_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor: compare every result transfer with the oldest expected view,
    // and stall the result channel at random unless the flow is held steady.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ch.ready <= 1'b0;
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (predicted_views.size() == 0)
                    report_mismatch("unexpected result, top", 32'(rsp_ch.top_value), 32'd0);
                else
                begin
                    stack_view_t want;
                    want = predicted_views.pop_front();
                    if (rsp_ch.top_value !== want.top)
                        report_mismatch("top_value", 32'(rsp_ch.top_value), 32'(want.top));
                    if (rsp_ch.stack_depth !== want.depth)
                        report_mismatch("stack_depth", 32'(rsp_ch.stack_depth),
                                        32'(want.depth));
                    if (rsp_ch.status !== want.status)
                        report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
                end
            end
            rsp_ch.ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Queue one command and track the depth it should leave, roughly.
    function automatic void add_item(input logic [CMD_W-1:0] c, input logic [DATA_W-1:0] v);
        alu_item_t it;
        it.cmd   = c;
        it.value = v;
        cmd_backlog.push_back(it);
        if (c == CMD_PUSH || (c == CMD_RAND && v != '0))
        begin
            if (gen_depth < STACK_DEPTH)
                gen_depth++;
        end
        else if (c >= CMD_ADD && c <= CMD_LT && gen_depth >= 2)
            gen_depth--;
    endfunction

    // Operand words lean toward the edges and small numbers, and zero for divisors.
    function automatic logic [DATA_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8)       return 16'h0000;
        else if (r < 14) return 16'h0001;
        else if (r < 20) return 16'hFFFF;
        else if (r < 24) return 16'h8000;
        else if (r < 28) return 16'h7FFF;
        else if (r < 50) return DATA_W'($urandom_range(0, 15));
        else             return DATA_W'($urandom);
    endfunction

    function automatic logic [DATA_W-1:0] pick_range();
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)       return 16'h0000;
        else if (r < 12) return 16'h0001;
        else if (r < 18) return 16'hFFFF;
        else if (r < 60) return DATA_W'($urandom_range(2, 20));
        else             return DATA_W'($urandom);
    endfunction

    function automatic logic [CMD_W-1:0] pick_binary();
        return CMD_W'($urandom_range(CMD_ADD, CMD_LT));
    endfunction

    // Push until full, then push once more and ask for a random word: both overflow.
    function automatic void add_fill_burst();
        while (gen_depth < STACK_DEPTH)
            add_item(CMD_PUSH, pick_word());
        add_item(CMD_PUSH, pick_word());
        add_item(CMD_RAND, DATA_W'($urandom_range(1, 65535)));
    endfunction

    // Mostly well-formed expression traffic: operands pushed, operators applied,
    // with underflow at the bottom, overflow at the top, and a little noise.
    task automatic queue_expression_mix(input int count);
        int r;
        @(negedge clk);
        add_fill_burst();
        for (int i = 0; i < count; i++)
        begin
            r = $urandom_range(0, 99);
            if (r < 2)
                add_fill_burst();
            else if (r < 6)
                add_item(CMD_W'($urandom_range(0, 15)), DATA_W'($urandom));
            else if (gen_depth < 2)
            begin
                r = $urandom_range(0, 99);
                if (r < 80)      add_item(CMD_PUSH, pick_word());
                else if (r < 90) add_item(CMD_RAND, pick_range());
                else             add_item(pick_binary(), DATA_W'($urandom));
            end
            else if (gen_depth >= STACK_DEPTH)
            begin
                r = $urandom_range(0, 99);
                if (r < 15)      add_item(CMD_PUSH, pick_word());
                else if (r < 25) add_item(CMD_RAND, pick_range());
                else             add_item(pick_binary(), DATA_W'($urandom));
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 40)      add_item(CMD_PUSH, pick_word());
                else if (r < 50) add_item(CMD_RAND, pick_range());
                else             add_item(pick_binary(), DATA_W'($urandom));
            end
        end
    endtask

    // Hold the sender until every command is out and every result is back,
    // then let the block settle before touching its register.
    task automatic wait_drained();
        while (cmd_backlog.size() != 0 || req_ch.valid || predicted_views.size() != 0)
            @(posedge clk);
        repeat (LATENCY_CYCLES) @(posedge clk);
        gen_depth = shadow_held;
    endtask

    // Write the seed register over the config port, then read it back.
    task automatic write_seed(input logic [DATA_W-1:0] s);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_INIT_SEED, 2'b00};
        pwdata  <= {16'h0000, s};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // The write reloads the running seed at once.
        shadow_seed = s;
        @(posedge clk);
        psel    <= 1'b1;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[DATA_W-1:0] !== s)
            report_mismatch("seed readback", prdata, {16'h0000, s});
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Main sequence: directed edge cases, then phases of random expressions
    // under different seeds, draining in between.
    initial
    begin
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        req_ch.valid = 1'b0;
        req_ch.cmd   = CMD_NULL;
        req_ch.value = '0;
        rsp_ch.ready = 1'b0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed part, with the seed at its reset value of zero.
        @(negedge clk);
        add_item(CMD_LT,      16'h0000);  // underflow on an empty stack
        add_item(CMD_PUSH,    16'hFFFF);
        add_item(CMD_ADD,     16'h0000);  // underflow with one word held
        add_item(CMD_PUSH,    16'hFFFF);
        add_item(CMD_MUL,     16'h0000);  // product wraps to one
        add_item(CMD_PUSH,    16'hFFFF);
        add_item(CMD_ADD,     16'h0000);  // sum wraps to zero
        add_item(CMD_PUSH,    16'h0000);
        add_item(CMD_DIV,     16'h0000);  // divide by zero, stack kept
        add_item(CMD_MOD,     16'h0000);  // modulo by zero, stack kept
        add_item(CMD_EQ,      16'h0000);
        add_item(CMD_RAND,    16'h0000);  // zero range, seed kept
        add_item(CMD_RAND,    16'hFFFF);
        add_item(CMD_NE,      16'h0000);
        add_item(CMD_RAND,    16'h0001);  // range of one always gives zero
        add_item(CMD_OR,      16'h0000);
        add_item(CMD_PUSH,    16'h8000);
        add_item(CMD_GT,      16'h0000);
        add_item(CMD_PUSH,    16'h7FFF);
        add_item(CMD_LT,      16'hFFFF);
        add_item(CMD_PUSH,    16'hFFFF);
        add_item(CMD_SUB,     16'h0000);  // smaller minus larger floors at zero
        add_item(CMD_SPARE_E, 16'hFFFF);
        add_item(CMD_SPARE_F, 16'h5A5A);
        add_item(CMD_NULL,    16'hA5A5);
        wait_drained();

        // Top seed; drain once mid-phase, between two runs of mixed traffic.
        write_seed(16'hFFFF);
        queue_expression_mix(100);
        wait_drained();
        queue_expression_mix(90);
        wait_drained();

        // Random seed, long stretch with no idling on either side.
        write_seed(DATA_W'($urandom));
        @(negedge clk);
        steady_flow = 1'b1;
        queue_expression_mix(180);
        wait_drained();
        @(negedge clk);
        steady_flow = 1'b0;

        write_seed(16'h0000);
        queue_expression_mix(180);
        wait_drained();

        write_seed(DATA_W'($urandom));
        queue_expression_mix(180);
        wait_drained();

        if (mismatches == 0)
            $display("** stack_expression_alu_unit: PASSED **");
        else
            $display("** stack_expression_alu_unit: FAILED **");
        $finish;
    end

    // Watchdog: drop the run if it hangs.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("** stack_expression_alu_unit: FAILED **");
        $finish;
    end

endmodule

@@ filelist.f @@
design/sea_pkg.sv
design/sea_if.sv
design/sea_stack.sv
design/sea_div.sv
design/stack_expression_alu_unit.sv
sim/testbench.sv
